FILE: rtl/core/rcg_pkg.sv
// rcg_pkg: shared types and constants of the roberts cross gradient block
// used by every file under rtl/core; depends on nothing else

package rcg_pkg;

	// field and register widths
	localparam int PIXEL_BITS     = 8;
	localparam int MAG_BITS       = 9;
	localparam int OUT_TDATA_BITS = 16;
	localparam int IMG_W_BITS     = 12;
	localparam int IMG_H_BITS     = 13;
	localparam int ROW_BITS       = 12;
	localparam int MAX_HEIGHT     = 4096;
	localparam int SUM_BITS       = 18;
	localparam logic [MAG_BITS-1:0] MAG_MAX = 9'd360;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IMG_W_BITS-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [IMG_H_BITS-1:0] RESET_HEIGHT = 13'd480;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;
	localparam int QCW    = 3;

	// one classified item: absolute diagonal differences and end-of-frame flag
	typedef struct packed {
		logic                  last;
		logic [PIXEL_BITS-1:0] dy;
		logic [PIXEL_BITS-1:0] dx;
	} diff_item_t;

endpackage

FILE: rtl/core/rcg_front.sv
// rcg_front: raster counters, line store and diagonal differences
// depends on rcg_pkg

module rcg_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_ready,
	input  logic [rcg_pkg::PIXEL_BITS-1:0]   pixel,
	input  logic [rcg_pkg::IMG_W_BITS-1:0]   image_width,
	input  logic [rcg_pkg::IMG_H_BITS-1:0]   image_height,
	input  logic [rcg_pkg::QCW-1:0]          q_count,
	output logic                             push,
	output rcg_pkg::diff_item_t              push_item
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WLG = $clog2(MAX_WIDTH + 1);
	localparam int WW  = (WLG > rcg_pkg::IMG_W_BITS) ? WLG : rcg_pkg::IMG_W_BITS;
	localparam int HW  = rcg_pkg::ROW_BITS + 1;

	logic [CW-1:0]                   col_q;
	logic [rcg_pkg::ROW_BITS-1:0]    row_q;
	logic [rcg_pkg::PIXEL_BITS-1:0]  left_q;
	logic [rcg_pkg::PIXEL_BITS-1:0]  ul_q;
	logic [rcg_pkg::PIXEL_BITS-1:0]  row_mem [MAX_WIDTH];

	logic                            valid_s1;
	logic                            res_s1;
	logic                            last_s1;
	logic [rcg_pkg::PIXEL_BITS-1:0]  pix_s1;
	logic [rcg_pkg::PIXEL_BITS-1:0]  left_s1;
	logic [rcg_pkg::PIXEL_BITS-1:0]  above_s1;

	logic [WW-1:0] w_ext;
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic          row_end;
	logic          frame_end;
	logic          acc;

	function automatic logic [rcg_pkg::PIXEL_BITS-1:0] abs_diff(
		input logic [rcg_pkg::PIXEL_BITS-1:0] a,
		input logic [rcg_pkg::PIXEL_BITS-1:0] b
	);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// clamp the frame size to what the line store holds
	always_comb begin
		w_ext = WW'(image_width);
		if (w_ext < WW'(2)) begin
			eff_w = WW'(2);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = w_ext;
		end
		if (image_height < HW'(2)) begin
			eff_h = HW'(2);
		end else if (image_height > HW'(rcg_pkg::MAX_HEIGHT)) begin
			eff_h = HW'(rcg_pkg::MAX_HEIGHT);
		end else begin
			eff_h = image_height;
		end
	end

	// row and frame end detection
	assign row_end   = (WW'(col_q) + WW'(1)) >= eff_w;
	assign frame_end = row_end && ((HW'(row_q) + HW'(1)) >= eff_h);

	// take a pixel only when the queue can absorb the stage ahead of it
	assign pixel_ready = (q_count + rcg_pkg::QCW'(valid_s1)) < rcg_pkg::QCW'(rcg_pkg::QDEPTH);
	assign acc         = pixel_valid && pixel_ready;

	// raster counters and neighbor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			ul_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				left_q <= pixel;
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : (row_q + rcg_pkg::ROW_BITS'(1));
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (valid_s1) begin
				ul_q <= above_s1;
			end
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel;
			left_s1 <= left_q;
			res_s1  <= (col_q != '0) && (row_q != '0);
			last_s1 <= frame_end;
		end
	end

	// line store: read the old entry and overwrite it with the new pixel
	always_ff @(posedge clk) begin
		if (acc) begin
			above_s1       <= row_mem[col_q];
			row_mem[col_q] <= pixel;
		end
	end

	// diagonal differences into the queue
	assign push           = valid_s1 && res_s1;
	assign push_item.dx   = abs_diff(ul_q, pix_s1);
	assign push_item.dy   = abs_diff(above_s1, left_s1);
	assign push_item.last = last_s1;

`ifndef SYNTH
	// after the frame's final pixel both counters restart
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && frame_end |=> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap at frame end");
`endif

endmodule

FILE: rtl/core/rcg_queue.sv
// rcg_queue: short item queue between the front and the back
// depends on rcg_pkg

module rcg_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  rcg_pkg::diff_item_t     push_item,
	input  logic                    pop_ready,
	output logic                    out_valid,
	output rcg_pkg::diff_item_t     out_item,
	output logic [rcg_pkg::QCW-1:0] count
);

	rcg_pkg::diff_item_t          entry_q [rcg_pkg::QDEPTH];
	logic [rcg_pkg::QPW-1:0]      head_q;
	logic [rcg_pkg::QPW-1:0]      tail_q;
	logic [rcg_pkg::QCW-1:0]      count_q;
	logic                         pop;

	assign out_valid = count_q != '0;
	assign out_item  = entry_q[head_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + rcg_pkg::QPW'(1);
			end
			if (pop) begin
				head_q <= head_q + rcg_pkg::QPW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + rcg_pkg::QCW'(1);
				2'b01:   count_q <= count_q - rcg_pkg::QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_item;
		end
	end

`ifndef SYNTH
	// fill level stays within the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rcg_pkg::QCW'(rcg_pkg::QDEPTH))
		else $error("queue fill level out of range");
	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != rcg_pkg::QCW'(rcg_pkg::QDEPTH)) || pop)
		else $error("push into full queue");
`endif

endmodule

FILE: rtl/core/rcg_back.sv
// rcg_back: sum of squares and pipelined integer square root
// depends on rcg_pkg

module rcg_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rcg_pkg::diff_item_t           in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rcg_pkg::MAG_BITS-1:0]  magnitude,
	output logic                          frame_last
);

	typedef struct packed {
		logic [9:0]                   rem;
		logic [rcg_pkg::MAG_BITS-1:0] root;
	} step_t;

	logic                          en;
	logic                          v_s1, v_s2, v_s3, v_s4;
	logic                          last_s1, last_s2, last_s3, last_s4;
	logic [rcg_pkg::SUM_BITS-1:0]  sum_s1, sum_s2, sum_s3;
	step_t                         st_s2, st_s3;
	logic [rcg_pkg::MAG_BITS-1:0]  root_s4;
	logic [15:0]                   sq_x, sq_y;
	step_t                         nx_s2, nx_s3, nx_s4;

	// one digit of the restoring square root
	function automatic step_t sqrt_step(input step_t s_in, input logic [1:0] pair);
		logic [11:0] acc_v;
		logic [11:0] trial;
		step_t       s_out;
		acc_v = {s_in.rem, pair};
		trial = {1'b0, s_in.root[7:0], 2'b01, 1'b0} >> 1;
		if (acc_v >= trial) begin
			s_out.rem  = 10'(acc_v - trial);
			s_out.root = {s_in.root[7:0], 1'b1};
		end else begin
			s_out.rem  = acc_v[9:0];
			s_out.root = {s_in.root[7:0], 1'b0};
		end
		return s_out;
	endfunction

	// the whole pipeline moves unless the output is held
	assign en       = !v_s4 || out_ready;
	assign in_ready = en;

	assign sq_x = in_item.dx * in_item.dx;
	assign sq_y = in_item.dy * in_item.dy;

	// three root digits per stage
	always_comb begin
		nx_s2 = '0;
		for (int i = 0; i < 3; i++) begin
			nx_s2 = sqrt_step(nx_s2, sum_s1[17 - 2 * i -: 2]);
		end
		nx_s3 = st_s2;
		for (int i = 0; i < 3; i++) begin
			nx_s3 = sqrt_step(nx_s3, sum_s2[11 - 2 * i -: 2]);
		end
		nx_s4 = st_s3;
		for (int i = 0; i < 3; i++) begin
			nx_s4 = sqrt_step(nx_s4, sum_s3[5 - 2 * i -: 2]);
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= rcg_pkg::SUM_BITS'(sq_x) + rcg_pkg::SUM_BITS'(sq_y);
			last_s1 <= in_item.last;
			st_s2   <= nx_s2;
			sum_s2  <= sum_s1;
			last_s2 <= last_s1;
			st_s3   <= nx_s3;
			sum_s3  <= sum_s2;
			last_s3 <= last_s2;
			root_s4 <= nx_s4.root;
			last_s4 <= last_s3;
		end
	end

	assign out_valid  = v_s4;
	assign magnitude  = root_s4;
	assign frame_last = last_s4;

`ifndef SYNTH
	// the root of two squared byte differences never exceeds its bound
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> root_s4 <= rcg_pkg::MAG_MAX)
		else $error("magnitude out of range");
`endif

endmodule

FILE: rtl/core/roberts_cross_gradient_magnitude.sv
// roberts_cross_gradient_magnitude: top level, configuration registers and wiring
// depends on rcg_pkg, rcg_front, rcg_queue, rcg_back
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata[7:0] pixel
// m_*       out  m_tvalid / m_tready    m_tdata[8:0] magnitude, m_tlast frame_last
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle sustained while m_tready stays high; the front is bounded by the
// single-port line store, which reads and rewrites one entry per pixel.
// a result passes the front stage register, the queue, then four back registers (squares,
// then three stages of three root digits each), the last of which drives the output.
// reset clears counters, neighbor pixels and valid bits; the line store is not cleared.
// a four-item queue parts front and back; s_tready drops only when it cannot absorb more.

module roberts_cross_gradient_magnitude #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rcg_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [8:0] magnitude
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [rcg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic [rcg_pkg::IMG_W_BITS-1:0] image_width_q;
	logic [rcg_pkg::IMG_H_BITS-1:0] image_height_q;
	logic                           push;
	rcg_pkg::diff_item_t            push_item;
	logic [rcg_pkg::QCW-1:0]        q_count;
	logic                           q_valid;
	logic                           q_ready;
	rcg_pkg::diff_item_t            q_item;
	logic [rcg_pkg::MAG_BITS-1:0]   magnitude;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= rcg_pkg::RESET_WIDTH;
			image_height_q <= rcg_pkg::RESET_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcg_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[rcg_pkg::IMG_W_BITS-1:0];
				rcg_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcg_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (s_tvalid),
		.pixel_ready  (s_tready),
		.pixel        (s_tdata),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.q_count      (q_count),
		.push         (push),
		.push_item    (push_item)
	);

	rcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop_ready (q_ready),
		.out_valid (q_valid),
		.out_item  (q_item),
		.count     (q_count)
	);

	rcg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_item    (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.magnitude  (magnitude),
		.frame_last (m_tlast)
	);

	// output word: magnitude in the low bits, zero filled
	assign m_tdata = {{(rcg_pkg::OUT_TDATA_BITS - rcg_pkg::MAG_BITS){1'b0}}, magnitude};

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for roberts_cross_gradient_magnitude, streams pixels through
// the block and compares each magnitude and frame flag against an in-bench line model
// depends on rcg_pkg and the rtl/core sources

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_PIXELS  = 2048;
	localparam int IDLE_PCT     = 21;
	localparam int PIPE_SETTLE  = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 290;
	localparam int RESET_RUN    = 24;

	// indexes with no register behind them
	localparam logic [rcg_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [rcg_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [rcg_pkg::MAG_BITS-1:0] magnitude;
		logic                         frame_last;
	} gradient_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [7:0]                         s_tdata;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [rcg_pkg::OUT_TDATA_BITS-1:0] m_tdata;
	logic                               m_tlast;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [rcg_pkg::CFG_IDX_BITS-1:0]   cfg_index;
	logic [rcg_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	// line model state
	logic [7:0]                     line_mem [0:LINE_PIXELS-1];
	logic [7:0]                     left_px;
	logic [7:0]                     upper_left_px;
	logic [10:0]                    col_q;
	logic [11:0]                    row_q;
	logic [rcg_pkg::IMG_W_BITS-1:0] width_reg;
	logic [rcg_pkg::IMG_H_BITS-1:0] height_reg;
	int unsigned                    store_span;

	gradient_t   gradients_due[$];
	int unsigned items_sent;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic        full_rate;

	roberts_cross_gradient_magnitude #(
		.MAX_WIDTH(LINE_PIXELS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// random back-pressure on the result side
	always @(negedge clk) begin
		m_tready <= full_rate || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// floor of the square root, one bit at a time from the top
	function automatic int unsigned root_floor(input int unsigned v);
		int unsigned r;
		int unsigned trial;
		r = 0;
		for (int b = 9; b >= 0; b--) begin
			trial = r | (1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// advance the line model by one accepted pixel, queue the gradient if one is due
	task automatic predict_gradient(input logic [7:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int          dx;
		int          dy;
		logic [7:0]  above;
		logic        row_end;
		logic        frame_end;
		gradient_t   g;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > LINE_PIXELS) w = LINE_PIXELS;
		h = height_reg;
		if (h < 2) h = 2;
		if (h > rcg_pkg::MAX_HEIGHT) h = rcg_pkg::MAX_HEIGHT;
		c = col_q;
		r = row_q;
		above = line_mem[c];
		row_end = (c + 1 >= w);
		frame_end = row_end && (r + 1 >= h);
		if (c > 0 && r > 0) begin
			dx = upper_left_px;
			dx = dx - int'(px);
			dy = above;
			dy = dy - int'(left_px);
			g.magnitude = rcg_pkg::MAG_BITS'(root_floor(dx * dx + dy * dy));
			g.frame_last = frame_end;
			gradients_due.push_back(g);
		end
		upper_left_px = above;
		line_mem[c] = px;
		left_px = px;
		if (c + 1 > store_span)
			store_span = c + 1;
		if (row_end) begin
			col_q = '0;
			row_q = frame_end ? '0 : 12'(r + 1);
		end else begin
			col_q = 11'(c + 1);
		end
	endtask

	// mostly random pixels, with the rails now and then
	function automatic logic [7:0] any_pixel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(input logic [7:0] px);
		while (!full_rate && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		predict_gradient(px);
		items_sent++;
	endtask

	// stop the pixel stream and let everything in flight come out
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (gradients_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rcg_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [rcg_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rcg_pkg::REG_IMAGE_WIDTH)
			width_reg = value[rcg_pkg::IMG_W_BITS-1:0];
		else if (idx == rcg_pkg::REG_IMAGE_HEIGHT)
			height_reg = value[rcg_pkg::IMG_H_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// send random pixels until the counters are back at the frame start
	task automatic finish_frame();
		while (col_q != 0 || row_q != 0)
			send_pixel(any_pixel());
	endtask

	// default geometry: a short run into the 640-pixel first row gives no gradient
	task automatic test_reset_geometry();
		repeat (RESET_RUN) send_pixel(any_pixel());
	endtask

	// reshape the frame while the counters sit inside it
	task automatic test_register_change_mid_frame();
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd2);
		repeat (3) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd2);
		finish_frame();
	endtask

	// hand-picked frames: full-swing stripes, flat, one-sided and clamped geometry
	task automatic test_directed_extremes();
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd3);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd3);
		// vertical stripes give the largest magnitude everywhere
		for (int i = 0; i < 9; i++)
			send_pixel((i % 3 == 1) ? 8'd0 : 8'd255);
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd0);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd1);
		repeat (4) send_pixel(8'd128);
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd1);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd0);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_idle();
		// bit 12 lies outside the width register and must be dropped
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'h1002);
		write_reg(REG_SPARE_A, 13'h1fff);
		write_reg(REG_SPARE_B, 13'h0005);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd2);
		for (int i = 1; i <= 4; i++)
			send_pixel(8'(i));
	endtask

	// widest line, exact and clamped from above, opened partway along a short second row
	task automatic test_max_width();
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd24);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd2);
		repeat (28) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd4095);
		repeat (9) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd2048);
		repeat (10) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd24);
		finish_frame();
	endtask

	// tallest frame, exact and clamped from above, on a two-pixel line, closed early
	task automatic test_max_height();
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd2);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd4096);
		repeat (16) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd8191);
		repeat (16) send_pixel(any_pixel());
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd2);
		finish_frame();
	endtask

	// back-to-back pixels and an always-ready sink
	task automatic test_full_rate();
		wait_idle();
		write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'd10);
		write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'd6);
		full_rate = 1'b1;
		repeat (2) begin
			send_pixel(any_pixel());
			finish_frame();
		end
		full_rate = 1'b0;
	endtask

	// random geometry per phase, whole frames, with some frames reshaped halfway
	task automatic test_random_frames();
		int unsigned                       stop_at;
		int unsigned                       w;
		int unsigned                       h;
		logic [rcg_pkg::CFG_DATA_BITS-1:0] wdata;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 1);
				1: w = $urandom_range(9, 40);
				default: w = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 9))
				0: h = $urandom_range(0, 1);
				1: h = $urandom_range(7, 12);
				default: h = $urandom_range(2, 6);
			endcase
			wdata = 13'(w);
			wdata[12] = $urandom_range(0, 1);
			write_reg(rcg_pkg::REG_IMAGE_WIDTH, wdata);
			write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'(h));
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
			send_pixel(any_pixel());
			finish_frame();
			// break into the next frame, then change its shape
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 30)) send_pixel(any_pixel());
				wait_idle();
				w = $urandom_range(2, 8);
				// past the first row, never widen beyond what the line store holds
				if (row_q != 0 && w > store_span)
					w = store_span;
				write_reg(rcg_pkg::REG_IMAGE_WIDTH, 13'(w));
				write_reg(rcg_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(2, 6)));
				finish_frame();
			end
		end
	endtask

	// compare every accepted result with the oldest gradient due
	always @(posedge clk) begin
		gradient_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (gradients_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tdata %h tlast %b",
					$time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = gradients_due.pop_front();
				if (m_tdata !== {{(rcg_pkg::OUT_TDATA_BITS-rcg_pkg::MAG_BITS){1'b0}},
						want.magnitude}) begin
					$display("%0t: magnitude mismatch, expected %0d, got %0d (tdata %h)",
						$time, want.magnitude, m_tdata[rcg_pkg::MAG_BITS-1:0], m_tdata);
					mismatches++;
				end
				if (m_tlast !== want.frame_last) begin
					$display("%0t: frame_last mismatch, expected %b, got %b",
						$time, want.frame_last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = rcg_pkg::REG_IMAGE_WIDTH;
		cfg_data      = '0;
		full_rate     = 1'b0;
		items_sent    = 0;
		for (int i = 0; i < LINE_PIXELS; i++)
			line_mem[i] = '0;
		left_px       = '0;
		upper_left_px = '0;
		col_q         = '0;
		row_q         = '0;
		width_reg     = rcg_pkg::RESET_WIDTH;
		height_reg    = rcg_pkg::RESET_HEIGHT;
		store_span    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_register_change_mid_frame();
		test_directed_extremes();
		test_max_width();
		test_max_height();
		test_full_rate();
		test_random_frames();

		wait_idle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rcg_pkg.sv
rtl/core/rcg_front.sv
rtl/core/rcg_queue.sv
rtl/core/rcg_back.sv
rtl/core/roberts_cross_gradient_magnitude.sv
dv/tb.sv
